>>> hdl/hv_pkg.sv
`timescale 1ns / 1ps

package hv_pkg;

   // Angle scaling of the input fields: degrees times 2^ANGLE_FRAC_BITS.
   localparam int ANGLE_FRAC_BITS = 20;

   // Datapath widths.
   localparam int CORDIC_W = 34;   // signed CORDIC x, y, z
   localparam int Q30_W    = 32;   // signed Q30 trig values
   localparam int MAG_Q30_W = 31;  // magnitude of a Q30 value, at most 2^30
   localparam int SQRT_W   = 62;   // radicand and partial root of the integer root
   localparam int SQRT_STEPS = 31; // one result bit per step
   localparam int ROOT_W   = 31;

   localparam int DEG2RAD_W = 31;
   localparam logic [DEG2RAD_W-1:0] DEG2RAD_Q36 = 31'd1199381129;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam int DIAM_W = 24;
   localparam logic [DIAM_W-1:0] DIAMETER_M = 24'd12742000;
   localparam int DIST_W = 25;
   localparam logic [DIST_W-1:0] HALF_CIRC_M = 25'd20015087;
   localparam logic [MAG_Q30_W-1:0] Q30_ONE = 31'h4000_0000;

   // round(atan(2^-i) * 2^30)
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd843314857;
         5'd1:  r = 32'd497837829;
         5'd2:  r = 32'd263043837;
         5'd3:  r = 32'd133525159;
         5'd4:  r = 32'd67021687;
         5'd5:  r = 32'd33543516;
         5'd6:  r = 32'd16775851;
         5'd7:  r = 32'd8388437;
         5'd8:  r = 32'd4194283;
         5'd9:  r = 32'd2097149;
         5'd10: r = 32'd1048576;
         5'd11: r = 32'd524288;
         5'd12: r = 32'd262144;
         5'd13: r = 32'd131072;
         5'd14: r = 32'd65536;
         5'd15: r = 32'd32768;
         5'd16: r = 32'd16384;
         5'd17: r = 32'd8192;
         5'd18: r = 32'd4096;
         5'd19: r = 32'd2048;
         5'd20: r = 32'd1024;
         5'd21: r = 32'd512;
         5'd22: r = 32'd256;
         5'd23: r = 32'd128;
         5'd24: r = 32'd64;
         5'd25: r = 32'd32;
         5'd26: r = 32'd16;
         5'd27: r = 32'd8;
         5'd28: r = 32'd4;
         5'd29: r = 32'd2;
         5'd30: r = 32'd1;
         5'd31: r = 32'd0;
      endcase
      return r;
   endfunction

   // Limit a CORDIC coordinate to [-1, 1] in Q30.
   function automatic logic signed [Q30_W-1:0] clamp_q30(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] one;
      logic signed [Q30_W-1:0] r;
      one = signed'(CORDIC_W'(Q30_ONE));
      if (v > one) begin
         r = Q30_W'(one);
      end else if (v < -one) begin
         r = Q30_W'(-one);
      end else begin
         r = Q30_W'(v);
      end
      return r;
   endfunction

endpackage

>>> hdl/hv_cordic_cell.sv
`timescale 1ns / 1ps

module hv_cordic_cell #(
   parameter int STAGE     = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [hv_pkg::CORDIC_W-1:0]    in_x,
   input  logic signed [hv_pkg::CORDIC_W-1:0]    in_y,
   input  logic signed [hv_pkg::CORDIC_W-1:0]    in_z,
   output logic                                  out_valid,
   output logic signed [hv_pkg::CORDIC_W-1:0]    out_x,
   output logic signed [hv_pkg::CORDIC_W-1:0]    out_y,
   output logic signed [hv_pkg::CORDIC_W-1:0]    out_z
);

   localparam logic signed [hv_pkg::CORDIC_W-1:0] ATAN =
      signed'(hv_pkg::CORDIC_W'(hv_pkg::atan_q30(5'(STAGE))));

   logic                                valid_ff;
   logic signed [hv_pkg::CORDIC_W-1:0]  x_ff, y_ff, z_ff;
   logic signed [hv_pkg::CORDIC_W-1:0]  x_in, y_in, z_in;
   logic signed [hv_pkg::CORDIC_W-1:0]  dx, dy;
   logic                                ccw;

   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      // rotation follows the residual angle, vectoring drives y to zero
      ccw = VECTORING ? !(in_y > 0) : (in_z >= 0);
      if (ccw) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

>>> hdl/hv_sqrt_cell.sv
`timescale 1ns / 1ps

module hv_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [hv_pkg::SQRT_W-1:0]   in_v,
   input  logic [hv_pkg::SQRT_W-1:0]   in_res,
   output logic                        out_valid,
   output logic [hv_pkg::SQRT_W-1:0]   out_v,
   output logic [hv_pkg::SQRT_W-1:0]   out_res
);

   localparam logic [hv_pkg::SQRT_W-1:0] BIT =
      hv_pkg::SQRT_W'(1) << (2 * (hv_pkg::SQRT_STEPS - 1 - STEP));

   logic                        valid_ff;
   logic [hv_pkg::SQRT_W-1:0]   v_ff, res_ff;
   logic [hv_pkg::SQRT_W-1:0]   v_in, res_in, trial;

   always_comb begin
      trial = in_res + BIT;
      if (in_v >= trial) begin
         v_in   = in_v - trial;
         res_in = (in_res >> 1) + BIT;
      end else begin
         v_in   = in_v;
         res_in = in_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_v     = v_ff;
   assign out_res   = res_ff;

endmodule

>>> hdl/hv_isqrt.sv
`timescale 1ns / 1ps

module hv_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [hv_pkg::SQRT_W-1:0]   in_v,
   output logic                        out_valid,
   output logic [hv_pkg::ROOT_W-1:0]   out_root
);

   localparam int N = hv_pkg::SQRT_STEPS;

   logic                        valid_w [0:N];
   logic [hv_pkg::SQRT_W-1:0]   v_w     [0:N];
   logic [hv_pkg::SQRT_W-1:0]   res_w   [0:N];

   assign valid_w[0] = in_valid;
   assign v_w[0]     = in_v;
   assign res_w[0]   = '0;

   for (genvar k = 0; k < N; k++) begin : g_step
      hv_sqrt_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_w[k]),
         .in_v      (v_w[k]),
         .in_res    (res_w[k]),
         .out_valid (valid_w[k+1]),
         .out_v     (v_w[k+1]),
         .out_res   (res_w[k+1])
      );
   end

   assign out_valid = valid_w[N];
   assign out_root  = res_w[N][hv_pkg::ROOT_W-1:0];

endmodule

>>> hdl/hv_sincos.sv
`timescale 1ns / 1ps

module hv_sincos #(
   parameter int IN_W   = 28,
   parameter int FRAC   = 20,
   parameter int STAGES = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [IN_W-1:0]             in_angle,
   output logic                               out_valid,
   output logic signed [hv_pkg::Q30_W-1:0]    out_sin,
   output logic signed [hv_pkg::Q30_W-1:0]    out_cos
);

   localparam int AW      = 32;
   localparam int CW      = hv_pkg::CORDIC_W;
   localparam int FULL_I  = 360 * (2 ** FRAC);
   localparam int HALF_I  = 180 * (2 ** FRAC);
   localparam int QUART_I = 90 * (2 ** FRAC);
   localparam logic signed [AW-1:0] FULL  = AW'(FULL_I);
   localparam logic signed [AW-1:0] HALF  = AW'(HALF_I);
   localparam logic signed [AW-1:0] QUART = AW'(QUART_I);
   localparam int MAG_W = $clog2(QUART_I + 1);
   localparam int PW    = MAG_W + hv_pkg::DEG2RAD_W;
   localparam logic [PW:0] RND = (PW + 1)'(1) << (FRAC + 5);

   // wrap stage
   logic                    v_w_ff;
   logic signed [AW-1:0]    wrap_ff, wrap_in, ang;
   // fold stage
   logic                    v_f_ff, negr_f_ff, negc_f_ff, negr_f_in, negc_f_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [AW-1:0]    fold;
   // multiply stage
   logic                    v_m_ff, negr_m_ff, negc_m_ff;
   logic [PW-1:0]           prod_ff, prod_in;
   // radian stage
   logic                    v_z_ff, negc_z_ff;
   logic signed [CW-1:0]    z_ff, z_in, zmag;
   logic [PW:0]             zsum;
   // cosine sign, carried beside the cells
   logic                    negc_d_ff [0:STAGES-1];
   // output stage
   logic                    v_o_ff;
   logic signed [hv_pkg::Q30_W-1:0] sin_ff, cos_ff, sin_in, cos_in;

   logic                    valid_w [0:STAGES];
   logic signed [CW-1:0]    x_w [0:STAGES];
   logic signed [CW-1:0]    y_w [0:STAGES];
   logic signed [CW-1:0]    z_w [0:STAGES];

   always_comb begin
      ang = AW'(in_angle);
      priority if (ang >= HALF) begin
         wrap_in = ang - FULL;
      end else if (ang < -HALF) begin
         wrap_in = ang + FULL;
      end else begin
         wrap_in = ang;
      end
   end

   always_comb begin
      negc_f_in = 1'b0;
      priority if (wrap_ff > QUART) begin
         fold      = HALF - wrap_ff;
         negc_f_in = 1'b1;
      end else if (wrap_ff < -QUART) begin
         fold      = -HALF - wrap_ff;
         negc_f_in = 1'b1;
      end else begin
         fold = wrap_ff;
      end
      negr_f_in = fold < 0;
      mag_in    = negr_f_in ? MAG_W'(-fold) : MAG_W'(fold);
   end

   assign prod_in = PW'(mag_ff) * PW'(hv_pkg::DEG2RAD_Q36);

   always_comb begin
      zsum = {1'b0, prod_ff} + RND;
      zmag = signed'(CW'(zsum >> (FRAC + 6)));
      z_in = negr_m_ff ? -zmag : zmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_w_ff <= 1'b0;
         v_f_ff <= 1'b0;
         v_m_ff <= 1'b0;
         v_z_ff <= 1'b0;
         v_o_ff <= 1'b0;
      end else if (en) begin
         v_w_ff <= in_valid;
         v_f_ff <= v_w_ff;
         v_m_ff <= v_f_ff;
         v_z_ff <= v_m_ff;
         v_o_ff <= valid_w[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff   <= wrap_in;
         mag_ff    <= mag_in;
         negr_f_ff <= negr_f_in;
         negc_f_ff <= negc_f_in;
         prod_ff   <= prod_in;
         negr_m_ff <= negr_f_ff;
         negc_m_ff <= negc_f_ff;
         z_ff      <= z_in;
         negc_z_ff <= negc_m_ff;
         negc_d_ff[0] <= negc_z_ff;
         for (int k = 1; k < STAGES; k++) begin
            negc_d_ff[k] <= negc_d_ff[k-1];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign valid_w[0] = v_z_ff;
   assign x_w[0]     = hv_pkg::CORDIC_GAIN_Q30;
   assign y_w[0]     = '0;
   assign z_w[0]     = z_ff;

   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      hv_cordic_cell #(.STAGE(k), .VECTORING(1'b0)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_w[k]),
         .in_x      (x_w[k]),
         .in_y      (y_w[k]),
         .in_z      (z_w[k]),
         .out_valid (valid_w[k+1]),
         .out_x     (x_w[k+1]),
         .out_y     (y_w[k+1]),
         .out_z     (z_w[k+1])
      );
   end

   always_comb begin
      sin_in = hv_pkg::clamp_q30(y_w[STAGES]);
      cos_in = hv_pkg::clamp_q30(negc_d_ff[STAGES-1] ? -x_w[STAGES] : x_w[STAGES]);
   end

   assign out_valid = v_o_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

>>> hdl/haversine_distance.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload (low bit first)
// req_      in         req_tvalid/req_tready  lat_a[27:0] lon_a[56:28] lat_b[84:57]
//                                             lon_b[113:85], zero pad to 120 bits
// rsp_      out        rsp_tvalid/rsp_tready  distance_m[24:0], zero pad to 32 bits
//
// One transaction is taken per cycle while the pipeline advances; each result passes
// through the two CORDIC chains and the two 31-step root chains. Synchronous
// active-high reset clears all valid flags.
// All stages advance together; they hold only while the output register is full
// and rsp_tready is low, and then req_tready drops as well.

module haversine_distance #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,   // lat_a, lon_a, lat_b, lon_b
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata    // distance_m
);

   localparam int CW = hv_pkg::CORDIC_W;
   localparam int MW = hv_pkg::MAG_Q30_W;
   localparam int PW = 2 * MW;
   localparam int N  = CORDIC_STAGES;
   localparam int SN = hv_pkg::SQRT_STEPS;
   localparam int DPW = MW + hv_pkg::DIAM_W;
   localparam logic [PW-1:0] RND_PW = PW'(1) << 29;
   localparam logic [DPW-1:0] RND_D = DPW'(1) << 29;

   logic adv;   // advance every stage

   // input fields
   logic signed [27:0] lat_a, lat_b;
   logic signed [28:0] lon_a, lon_b;

   // input register: angle differences and the two latitudes
   logic               v0_ff;
   logic signed [28:0] dlat_ff;
   logic signed [29:0] dlon_ff;
   logic signed [27:0] lat_a_ff, lat_b_ff;

   // trig lanes
   logic [3:0]                       lane_valid;
   logic signed [hv_pkg::Q30_W-1:0]  s1, s2, ca, cb;

   // products
   logic              v_p1_ff, neg_p1_ff;
   logic [PW-1:0]     p_ss1_ff, p_cc_ff, p_ss2_ff;
   logic [MW-1:0]     m_s1, m_s2, m_ca, m_cb;
   logic              v_p2_ff, neg_p2_ff;
   logic [MW-1:0]     ss1_p2_ff, cc_p2_ff, ss2_p2_ff;
   logic              v_p3_ff, neg_p3_ff;
   logic [PW-1:0]     p_t_ff;
   logic [MW-1:0]     ss1_p3_ff;
   logic              v_p4_ff, neg_p4_ff;
   logic [MW-1:0]     t_p4_ff, ss1_p4_ff;
   logic              v_p5_ff;
   logic [MW-1:0]     a_ff, a_in;
   logic signed [MW+1:0] a_sum;

   // first root
   logic                        r1_valid;
   logic [hv_pkg::ROOT_W-1:0]   r1_root;
   logic                        v_r0_ff;
   logic [MW-1:0]               s_r0_ff;

   // 1 - s^2
   logic                        v_q1_ff, v_q2_ff;
   logic [PW-1:0]               sq_q1_ff;
   logic [MW-1:0]               s_q1_ff, s_q2_ff;
   logic [hv_pkg::SQRT_W-1:0]   rem_q2_ff;

   // second root and the sine carried beside it
   logic                        r2_valid;
   logic [hv_pkg::ROOT_W-1:0]   r2_root;
   logic [MW-1:0]               s_d_ff [0:SN-1];

   // arcsine chain
   logic                valid_w [0:N];
   logic signed [CW-1:0] x_w [0:N];
   logic signed [CW-1:0] y_w [0:N];
   logic signed [CW-1:0] z_w [0:N];

   // meters
   logic               v_d1_ff;
   logic [DPW-1:0]     pd_ff;
   logic [MW-1:0]      ang_in;
   logic               out_valid_ff;
   logic [hv_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [DPW-1:0]     dist_sum;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign lat_a = signed'(req_tdata[27:0]);
   assign lon_a = signed'(req_tdata[56:28]);
   assign lat_b = signed'(req_tdata[84:57]);
   assign lon_b = signed'(req_tdata[113:85]);

   always_ff @(posedge clock) begin
      if (adv) begin
         dlat_ff  <= 29'(lat_b) - 29'(lat_a);
         dlon_ff  <= 30'(lon_b) - 30'(lon_a);
         lat_a_ff <= lat_a;
         lat_b_ff <= lat_b;
      end
   end

   // Half differences use one more fraction bit, so the two difference lanes see dlat/2 and dlon/2.
   hv_sincos #(.IN_W(29), .FRAC(hv_pkg::ANGLE_FRAC_BITS + 1), .STAGES(N)) u_lane_dlat (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v0_ff), .in_angle(dlat_ff),
      .out_valid(lane_valid[0]), .out_sin(s1), .out_cos()
   );
   hv_sincos #(.IN_W(30), .FRAC(hv_pkg::ANGLE_FRAC_BITS + 1), .STAGES(N)) u_lane_dlon (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v0_ff), .in_angle(dlon_ff),
      .out_valid(lane_valid[1]), .out_sin(s2), .out_cos()
   );
   hv_sincos #(.IN_W(28), .FRAC(hv_pkg::ANGLE_FRAC_BITS), .STAGES(N)) u_lane_lat_a (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v0_ff), .in_angle(lat_a_ff),
      .out_valid(lane_valid[2]), .out_sin(), .out_cos(ca)
   );
   hv_sincos #(.IN_W(28), .FRAC(hv_pkg::ANGLE_FRAC_BITS), .STAGES(N)) u_lane_lat_b (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v0_ff), .in_angle(lat_b_ff),
      .out_valid(lane_valid[3]), .out_sin(), .out_cos(cb)
   );

   // magnitudes of the Q30 terms
   always_comb begin
      m_s1 = (s1 < 0) ? MW'(-s1) : MW'(s1);
      m_s2 = (s2 < 0) ? MW'(-s2) : MW'(s2);
      m_ca = (ca < 0) ? MW'(-ca) : MW'(ca);
      m_cb = (cb < 0) ? MW'(-cb) : MW'(cb);
   end

   // a = s1^2 + ca*cb*s2^2, clamped to [0, 1]
   always_comb begin
      a_sum = neg_p4_ff ? $signed({2'b00, ss1_p4_ff}) - $signed({2'b00, t_p4_ff})
                        : $signed({2'b00, ss1_p4_ff}) + $signed({2'b00, t_p4_ff});
      priority if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > $signed({2'b00, hv_pkg::Q30_ONE})) begin
         a_in = hv_pkg::Q30_ONE;
      end else begin
         a_in = MW'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // first products, rounded on magnitude next
         p_ss1_ff  <= PW'(m_s1) * PW'(m_s1);
         p_cc_ff   <= PW'(m_ca) * PW'(m_cb);
         p_ss2_ff  <= PW'(m_s2) * PW'(m_s2);
         neg_p1_ff <= (ca < 0) != (cb < 0);
         ss1_p2_ff <= MW'((p_ss1_ff + RND_PW) >> 30);
         cc_p2_ff  <= MW'((p_cc_ff + RND_PW) >> 30);
         ss2_p2_ff <= MW'((p_ss2_ff + RND_PW) >> 30);
         neg_p2_ff <= neg_p1_ff;
         p_t_ff    <= PW'(cc_p2_ff) * PW'(ss2_p2_ff);
         neg_p3_ff <= neg_p2_ff;
         ss1_p3_ff <= ss1_p2_ff;
         t_p4_ff   <= MW'((p_t_ff + RND_PW) >> 30);
         neg_p4_ff <= neg_p3_ff;
         ss1_p4_ff <= ss1_p3_ff;
         a_ff      <= a_in;
      end
   end

   hv_isqrt u_root_a (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v_p5_ff),
      .in_v({1'b0, a_ff, 30'b0}),
      .out_valid(r1_valid), .out_root(r1_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s_r0_ff   <= (r1_root > hv_pkg::Q30_ONE) ? hv_pkg::Q30_ONE : r1_root;
         sq_q1_ff  <= PW'(s_r0_ff) * PW'(s_r0_ff);
         s_q1_ff   <= s_r0_ff;
         rem_q2_ff <= (hv_pkg::SQRT_W'(1) << 60) - sq_q1_ff;
         s_q2_ff   <= s_q1_ff;
         s_d_ff[0] <= s_q2_ff;
         for (int k = 1; k < SN; k++) begin
            s_d_ff[k] <= s_d_ff[k-1];
         end
      end
   end

   hv_isqrt u_root_c (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v_q2_ff),
      .in_v(rem_q2_ff),
      .out_valid(r2_valid), .out_root(r2_root)
   );

   // arcsine by vectoring (sqrt(1 - s^2), s) onto the x axis
   assign valid_w[0] = r2_valid;
   assign x_w[0]     = signed'(CW'(r2_root));
   assign y_w[0]     = signed'(CW'(s_d_ff[SN-1]));
   assign z_w[0]     = '0;

   for (genvar k = 0; k < N; k++) begin : g_asin
      hv_cordic_cell #(.STAGE(k), .VECTORING(1'b1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (valid_w[k]),
         .in_x      (x_w[k]),
         .in_y      (y_w[k]),
         .in_z      (z_w[k]),
         .out_valid (valid_w[k+1]),
         .out_x     (x_w[k+1]),
         .out_y     (y_w[k+1]),
         .out_z     (z_w[k+1])
      );
   end

   // drop a negative angle to zero, scale by the diameter, round, saturate
   always_comb begin
      ang_in   = (z_w[N] < 0) ? '0 : MW'(z_w[N]);
      dist_sum = (pd_ff + RND_D) >> 30;
      dist_in  = (dist_sum > DPW'(hv_pkg::HALF_CIRC_M)) ? hv_pkg::HALF_CIRC_M
                                                        : hv_pkg::DIST_W'(dist_sum);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff   <= DPW'(ang_in) * DPW'(hv_pkg::DIAMETER_M);
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v_p1_ff      <= 1'b0;
         v_p2_ff      <= 1'b0;
         v_p3_ff      <= 1'b0;
         v_p4_ff      <= 1'b0;
         v_p5_ff      <= 1'b0;
         v_r0_ff      <= 1'b0;
         v_q1_ff      <= 1'b0;
         v_q2_ff      <= 1'b0;
         v_d1_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_tvalid;
         v_p1_ff      <= &lane_valid;
         v_p2_ff      <= v_p1_ff;
         v_p3_ff      <= v_p2_ff;
         v_p4_ff      <= v_p3_ff;
         v_p5_ff      <= v_p4_ff;
         v_r0_ff      <= r1_valid;
         v_q1_ff      <= v_r0_ff;
         v_q2_ff      <= v_q1_ff;
         v_d1_ff      <= valid_w[N];
         out_valid_ff <= v_d1_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, dist_ff};

endmodule
